// ----- sv/fdm_pkg.sv -----
// Shared types and constants for the floor division and modulo unit.
package fdm_pkg;

	localparam int unsigned DataW = 64;
	localparam int unsigned HalfW = 32;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [0:0] {
		FUNC_DIV = 1'b0,
		FUNC_MOD = 1'b1
	} func_t;

	// Classified work handed from the front part to the divider.
	typedef struct packed {
		logic             want_mod;
		logic             wide;
		logic             zero;
		logic             neg_a;
		logic [DataW-1:0] num;     // dividend after the negative-dividend adjustment
		logic [DataW-1:0] den;     // divisor at the operating width
	} job_t;

	// Sign-extend from the low half when the operation is narrow.
	function automatic logic [DataW-1:0] fit_width(input logic [DataW-1:0] v,
		input logic wide);
		fit_width = wide ? v : {{HalfW{v[HalfW-1]}}, v[HalfW-1:0]};
	endfunction

endpackage

// ----- sv/fdm_front.sv -----
// Front part: takes items, reduces operands to width and classifies them.
module fdm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                func,
	input  logic                wide,
	input  logic signed [63:0]  dividend,
	input  logic signed [63:0]  divisor,
	input  logic                in_valid,
	output logic                in_ready,
	output fdm_pkg::job_t       job,
	output logic                job_valid,
	input  logic                job_ready
);
	import fdm_pkg::*;

	logic [DataW-1:0] a;
	logic [DataW-1:0] b;
	job_t             job_in;
	job_t             mem_q [QueueDepth];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	always_comb begin
		a = fit_width(dividend, wide);
		b = fit_width(divisor, wide);
		job_in.want_mod = (func_t'(func) == FUNC_MOD);
		job_in.wide     = wide;
		job_in.zero     = (b == '0);
		job_in.neg_a    = a[DataW-1];
		job_in.num      = a[DataW-1] ? fit_width(a - b + DataW'(1), wide) : a;
		job_in.den      = b;
	end

	assign in_ready  = (count_q != 2'(QueueDepth));
	assign push      = in_valid && in_ready;
	assign job_valid = (count_q != 2'd0);
	assign pop       = job_valid && job_ready;
	assign job       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(QueueDepth)) else $error("queue count overflow");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'(QueueDepth) |-> !in_ready) else $error("full queue accepted");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 2'd1) else $error("count step");
`endif

endmodule

// ----- sv/fdm_divider.sv -----
// Back part: pipelined restoring divider, one quotient bit per stage.
module fdm_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  fdm_pkg::job_t       job,
	input  logic                job_valid,
	output logic                job_ready,
	output logic signed [63:0]  result,
	output logic                divide_by_zero,
	output logic                out_valid,
	input  logic                out_ready
);
	import fdm_pkg::*;

	localparam int unsigned NStg = DataW + 2;

	// Stage 0 takes magnitudes; stages 1..DataW each retire one quotient bit;
	// the last stage fixes signs and applies the floor correction.
	logic             vld_q   [NStg];
	logic             mod_q   [NStg];
	logic             wide_q  [NStg];
	logic             zero_q  [NStg];
	logic             nega_q  [NStg];
	logic             qneg_q  [NStg];
	logic             xneg_q  [NStg];
	logic [DataW-1:0] den_q   [NStg];
	logic [DataW-1:0] dmag_q  [NStg];
	logic [DataW-1:0] rem_q   [NStg];
	logic [DataW-1:0] quo_q   [NStg];
	logic             adv;
	logic [DataW-1:0] res_q;
	logic             dz_q;
	logic             ov_q;
	logic [DataW-1:0] fin_q;
	logic [DataW-1:0] fin_r;
	logic [DataW-1:0] res_d;

	assign out_valid = ov_q;
	assign adv       = !ov_q || out_ready || !vld_q[NStg-1];
	assign job_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NStg; i++) vld_q[i] <= 1'b0;
			ov_q <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= job_valid;
			for (int i = 1; i < NStg; i++) vld_q[i] <= vld_q[i-1];
			if (vld_q[NStg-1]) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mod_q[0]  <= job.want_mod;
			wide_q[0] <= job.wide;
			zero_q[0] <= job.zero;
			nega_q[0] <= job.neg_a;
			xneg_q[0] <= job.num[DataW-1];
			qneg_q[0] <= job.num[DataW-1] ^ job.den[DataW-1];
			den_q[0]  <= job.den;
			dmag_q[0] <= job.den[DataW-1] ? -job.den : job.den;
			rem_q[0]  <= '0;
			quo_q[0]  <= job.num[DataW-1] ? -job.num : job.num;
			for (int i = 1; i < NStg - 1; i++) begin
				logic [DataW:0] tr;
				logic [DataW:0] df;
				tr = {rem_q[i-1], quo_q[i-1][DataW-1]};
				df = tr - {1'b0, dmag_q[i-1]};
				mod_q[i]  <= mod_q[i-1];
				wide_q[i] <= wide_q[i-1];
				zero_q[i] <= zero_q[i-1];
				nega_q[i] <= nega_q[i-1];
				xneg_q[i] <= xneg_q[i-1];
				qneg_q[i] <= qneg_q[i-1];
				den_q[i]  <= den_q[i-1];
				dmag_q[i] <= dmag_q[i-1];
				rem_q[i]  <= df[DataW] ? tr[DataW-1:0] : df[DataW-1:0];
				quo_q[i]  <= {quo_q[i-1][DataW-2:0], ~df[DataW]};
			end
			// Sign fix stage.
			mod_q[NStg-1]  <= mod_q[NStg-2];
			wide_q[NStg-1] <= wide_q[NStg-2];
			zero_q[NStg-1] <= zero_q[NStg-2];
			nega_q[NStg-1] <= nega_q[NStg-2];
			den_q[NStg-1]  <= den_q[NStg-2];
			fin_q <= fit_width(qneg_q[NStg-2] ? -quo_q[NStg-2] : quo_q[NStg-2],
				wide_q[NStg-2]);
			fin_r <= fit_width(xneg_q[NStg-2] ? -rem_q[NStg-2] : rem_q[NStg-2],
				wide_q[NStg-2]);
			if (vld_q[NStg-1]) begin
				res_q <= res_d;
				dz_q  <= zero_q[NStg-1];
			end
		end
	end

	always_comb begin
		if (zero_q[NStg-1])
			res_d = '0;
		else if (!mod_q[NStg-1])
			res_d = fin_q;
		else if (nega_q[NStg-1])
			res_d = fit_width(den_q[NStg-1] - DataW'(1) + fin_r, wide_q[NStg-1]);
		else
			res_d = fin_r;
	end

	assign result         = res_q;
	assign divide_by_zero = dz_q;

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> out_valid && !out_ready) else $error("pipeline stalled without cause");
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result == '0) else $error("zero divisor result");
`endif

endmodule

// ----- sv/floor_div_mod_unit.sv -----
// Top level of the floor division and modulo unit.
//
//  channel | direction | handshake             | payload
//  input   | in        | in_valid / in_ready   | func, wide, dividend, divisor
//  output  | out       | out_valid / out_ready | result, divide_by_zero
//
// An accepted item passes through the front queue, magnitude setup, 64 divider
// stages (one quotient bit each), sign fixing and the output register. One item
// enters per cycle unless the divider stalls, as the divider is pipelined.
// Reset clears only control state; the divider advances as a whole and
// stalls only while a finished result waits at the output.
// The two-entry queue keeps accepting while the divider is stalled, until it fills.
module floor_div_mod_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic                wide,
	input  logic signed [63:0]  dividend,
	input  logic signed [63:0]  divisor,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [63:0]  result,
	output logic                divide_by_zero
);
	import fdm_pkg::*;

	job_t job;
	logic job_valid;
	logic job_ready;

	// Front: width reduction, zero check and the negative-dividend rewrite.
	fdm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (func),
		.wide      (wide),
		.dividend  (dividend),
		.divisor   (divisor),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready)
	);

	// Back: truncating divide and floor correction.
	fdm_divider u_div (
		.clk            (clk),
		.arst_n         (arst_n),
		.job            (job),
		.job_valid      (job_valid),
		.job_ready      (job_ready),
		.result         (result),
		.divide_by_zero (divide_by_zero),
		.out_valid      (out_valid),
		.out_ready      (out_ready)
	);

endmodule
